// ----- design/atrp_pkg.sv -----
// ----------------------------------------------------------------------------
// atrp_pkg: tilt angle package
// shared widths, constants, cordic step and output rounding for roll/pitch
// ----------------------------------------------------------------------------
package atrp_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int TABLE_LEN       = 24;
    localparam int N_STG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int SAMPLE_W  = 16;
    localparam int ROLL_W    = 16;
    localparam int PITCH_W   = 15;
    localparam int DATA_FRAC = 14;
    localparam int ACC_FRAC  = 24;
    localparam int DW        = 34;   // vector datapath
    localparam int AW        = 33;   // angle accumulator
    localparam int MW        = 32;   // magnitude into gain multiplier
    localparam int GAIN_W    = 30;
    localparam int RND_SH    = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic [GAIN_W-1:0]    INV_GAIN_Q30 = GAIN_W'(652032874);
    localparam logic signed [AW-1:0] DEG90_ACC    = AW'(longint'(90) << ACC_FRAC);
    localparam logic signed [AW-1:0] DEG180_ACC   = AW'(longint'(180) << ACC_FRAC);
    localparam logic [AW-1:0]        ROLL_LIM     = AW'(longint'(180) << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0]        PITCH_LIM    = AW'(longint'(90) << ANGLE_FRAC_BITS);
    localparam logic signed [ROLL_W-1:0]  ROLL_MAX_OUT  = ROLL_W'(ROLL_LIM);
    localparam logic signed [PITCH_W-1:0] PITCH_MAX_OUT = PITCH_W'(PITCH_LIM);

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] a;
        logic                 done;
    } t_vec;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [AW-1:0] atan_q24(input int idx);
        logic signed [AW-1:0] v;
        unique case (idx)
            0:  v = AW'(754974720);
            1:  v = AW'(445687602);
            2:  v = AW'(235489089);
            3:  v = AW'(119537938);
            4:  v = AW'(60000934);
            5:  v = AW'(30029717);
            6:  v = AW'(15018523);
            7:  v = AW'(7509720);
            8:  v = AW'(3754917);
            9:  v = AW'(1877466);
            10: v = AW'(938734);
            11: v = AW'(469367);
            12: v = AW'(234684);
            13: v = AW'(117342);
            14: v = AW'(58671);
            15: v = AW'(29335);
            16: v = AW'(14668);
            17: v = AW'(7334);
            18: v = AW'(3667);
            19: v = AW'(1833);
            20: v = AW'(917);
            21: v = AW'(458);
            22: v = AW'(229);
            23: v = AW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    // one vectoring micro-rotation; finished vectors pass unchanged
    function automatic t_vec cordic_iter(input t_vec v, input int idx);
        t_vec                 r;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        r  = v;
        dx = v.y >>> idx;
        dy = v.x >>> idx;
        if (!v.done) begin
            if (!v.y[DW-1]) begin
                r.x = v.x + dx;
                r.y = v.y - dy;
                r.a = v.a + atan_q24(idx);
            end else begin
                r.x = v.x - dx;
                r.y = v.y + dy;
                r.a = v.a - atan_q24(idx);
            end
        end
        return r;
    endfunction

    // round magnitude to nearest (ties away from zero), clamp, restore sign
    function automatic logic signed [AW-1:0] round_clamp(input logic signed [AW-1:0] acc,
                                                         input logic [AW-1:0] lim);
        logic [AW-1:0] m;
        m = acc[AW-1] ? AW'(-acc) : AW'(acc);
        m = (m + (AW'(1) << (RND_SH - 1))) >> RND_SH;
        if (m > lim) begin
            m = lim;
        end
        return acc[AW-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ----- design/atrp_if.sv -----
// ----------------------------------------------------------------------------
// atrp_if: sample and angle channels
// valid/ready channels carrying one accelerometer sample or one angle pair
// ----------------------------------------------------------------------------
interface atrp_in_if import atrp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atrp_out_if import atrp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;

    modport source (output valid, output roll_angle, output pitch_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// ----- design/accel_tilt_roll_pitch.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from a three-axis sample
// pipelined vectoring cordic pair producing tilt angles in 1/128 degree
// ----------------------------------------------------------------------------
// usage
//   i_sample carries one signed 16-bit x/y/z sample per transaction
//   o_angle returns roll = atan2(y, z) and pitch = atan2(-x, hypot(y, z)),
//   in degrees with ANGLE_FRAC_BITS fraction bits, one result per sample
//   datapath: input stage with roll pre-rotation, N_STG roll cordic stages,
//   gain multiply stage, pitch set-up stage, N_STG pitch cordic stages,
//   rounding/clamp output register
//   throughput: one sample per clock while the skid entry is empty; each cordic stage is one add/sub row
//   reset: synchronous active low, clears all valid bits and the skid entry;
//   the data registers are not reset
//   stall: when o_angle.ready is low the waiting result moves into a skid
//   register and the pipeline keeps accepting for that cycle; while the skid
//   holds a result the whole pipeline freezes and i_sample.ready is low
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch import atrp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    atrp_in_if.sink      i_sample,
    atrp_out_if.source   o_angle
);

    // global advance: pipeline moves whenever the skid entry is free
    logic w_en;

    // roll cordic pipeline
    t_vec                       r_roll   [N_STG+1];
    logic                       r_roll_v [N_STG+1];
    logic signed [SAMPLE_W-1:0] r_ax     [N_STG+1];
    t_vec                       n_roll0;
    logic signed [DW-1:0]       w_z;
    logic signed [DW-1:0]       w_y;

    // gain correction stage
    logic [MW+GAIN_W-1:0]       w_prod;
    logic signed [DW-1:0]       r_mul_r;
    logic signed [AW-1:0]       r_mul_roll;
    logic signed [SAMPLE_W-1:0] r_mul_ax;
    logic                       r_mul_v;

    // pitch cordic pipeline
    t_vec                       r_pitch   [N_STG+1];
    logic                       r_pitch_v [N_STG+1];
    logic signed [AW-1:0]       r_proll   [N_STG+1];
    t_vec                       n_pitch0;
    logic signed [DW-1:0]       w_py;

    // output register and skid entry
    logic signed [AW-1:0]       w_roll_full;
    logic signed [AW-1:0]       w_pitch_full;
    logic signed [ROLL_W-1:0]   r_out_roll;
    logic signed [PITCH_W-1:0]  r_out_pitch;
    logic                       r_out_v;
    logic signed [ROLL_W-1:0]   r_skid_roll;
    logic signed [PITCH_W-1:0]  r_skid_pitch;
    logic                       r_skid_valid;

    assign w_en           = !r_skid_valid;
    assign i_sample.ready = w_en;

    // ---------------- roll set-up: axis cases and quadrant fold ----------------
    assign w_z = DW'(i_sample.accel_z) <<< DATA_FRAC;
    assign w_y = DW'(i_sample.accel_y) <<< DATA_FRAC;

    always_comb begin
        n_roll0.x    = w_z;
        n_roll0.y    = w_y;
        n_roll0.a    = '0;
        n_roll0.done = 1'b0;
        priority if (w_y == '0) begin
            // on the z axis: 0 or +180 exactly
            n_roll0.x    = w_z[DW-1] ? -w_z : w_z;
            n_roll0.a    = w_z[DW-1] ? DEG180_ACC : '0;
            n_roll0.done = 1'b1;
        end else if (w_z == '0) begin
            // on the y axis: +-90 exactly
            n_roll0.x    = w_y[DW-1] ? -w_y : w_y;
            n_roll0.a    = w_y[DW-1] ? -DEG90_ACC : DEG90_ACC;
            n_roll0.done = 1'b1;
        end else if (w_z[DW-1]) begin
            // left half plane: rotate by 90 degrees into the right half
            if (!w_y[DW-1]) begin
                n_roll0.x = w_y;
                n_roll0.y = -w_z;
                n_roll0.a = DEG90_ACC;
            end else begin
                n_roll0.x = -w_y;
                n_roll0.y = w_z;
                n_roll0.a = -DEG90_ACC;
            end
        end else begin
            n_roll0.done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_v[0] <= 1'b0;
        end else if (w_en) begin
            r_roll_v[0] <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll[0] <= n_roll0;
            r_ax[0]   <= i_sample.accel_x;
        end
    end

    for (genvar k = 0; k < N_STG; k++) begin : g_roll
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_roll_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_roll_v[k+1] <= r_roll_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_roll[k+1] <= cordic_iter(r_roll[k], k);
                r_ax[k+1]   <= r_ax[k];
            end
        end
    end

    // ---------------- remove cordic gain from the yz magnitude ----------------
    // axis cases already hold the exact magnitude and skip the gain
    assign w_prod = r_roll[N_STG].x[MW-1:0] * INV_GAIN_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (w_en) begin
            r_mul_v <= r_roll_v[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul_r    <= r_roll[N_STG].done ? r_roll[N_STG].x
                                             : DW'(w_prod[MW+GAIN_W-1:GAIN_W]);
            r_mul_roll <= r_roll[N_STG].a;
            r_mul_ax   <= r_ax[N_STG];
        end
    end

    // ---------------- pitch set-up: vector (r, -x), r never negative ----------------
    assign w_py = -(DW'(r_mul_ax) <<< DATA_FRAC);

    always_comb begin
        n_pitch0.x    = r_mul_r;
        n_pitch0.y    = w_py;
        n_pitch0.a    = '0;
        n_pitch0.done = 1'b0;
        priority if (r_mul_ax == '0) begin
            // level on x: pitch is exactly 0
            n_pitch0.done = 1'b1;
        end else if (r_mul_r == '0) begin
            // y and z both zero: straight up or down
            n_pitch0.a    = w_py[DW-1] ? -DEG90_ACC : DEG90_ACC;
            n_pitch0.done = 1'b1;
        end else begin
            n_pitch0.done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_v[0] <= 1'b0;
        end else if (w_en) begin
            r_pitch_v[0] <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pitch[0] <= n_pitch0;
            r_proll[0] <= r_mul_roll;
        end
    end

    for (genvar k = 0; k < N_STG; k++) begin : g_pitch
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pitch_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_pitch_v[k+1] <= r_pitch_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pitch[k+1] <= cordic_iter(r_pitch[k], k);
                r_proll[k+1] <= r_proll[k];
            end
        end
    end

    // ---------------- rounding, clamp and output register ----------------
    assign w_roll_full  = round_clamp(r_proll[N_STG], ROLL_LIM);
    assign w_pitch_full = round_clamp(r_pitch[N_STG].a, PITCH_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_pitch_v[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_roll  <= w_roll_full[ROLL_W-1:0];
            r_out_pitch <= w_pitch_full[PITCH_W-1:0];
        end
    end

    // skid entry catches the result refused while the pipeline advanced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_angle.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_v && !o_angle.ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_roll  <= r_out_roll;
            r_skid_pitch <= r_out_pitch;
        end
    end

    assign o_angle.valid       = r_skid_valid | r_out_v;
    assign o_angle.roll_angle  = r_skid_valid ? r_skid_roll  : r_out_roll;
    assign o_angle.pitch_angle = r_skid_valid ? r_skid_pitch : r_out_pitch;

`ifndef SYNTH
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_angle.ready) |=>
        (r_skid_valid && $stable(r_skid_roll) && $stable(r_skid_pitch)))
        else $error("skid entry changed while the receiver stalled");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_out_v) && $stable(r_out_roll) && $stable(r_out_pitch)))
        else $error("output stage moved while the pipeline was frozen");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid |->
        (o_angle.roll_angle <= ROLL_MAX_OUT && o_angle.roll_angle >= -ROLL_MAX_OUT))
        else $error("roll angle outside +-180 degrees");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid |->
        (o_angle.pitch_angle <= PITCH_MAX_OUT && o_angle.pitch_angle >= -PITCH_MAX_OUT))
        else $error("pitch angle outside +-90 degrees");
`endif

endmodule

// ----- dv/accel_tilt_roll_pitch_tb.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_tb: tilt angle regression
// drives random and corner accelerometer samples through the roll/pitch
// pipeline under random stalls, and checks every angle pair against an
// in-bench integer cordic predictor
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch_tb;
    import atrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
    } t_sample;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
    } t_angles;

    logic i_clk;
    logic i_rst_n;

    atrp_in_if  sample_ch ();
    atrp_out_if angle_ch ();

    accel_tilt_roll_pitch dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_angle  (angle_ch.source)
    );

    t_sample pending_samples[$];
    t_angles expected_angles[$];

    int  n_sent;
    int  n_checked;
    int  n_mismatch;
    int  n_special;
    bit  calm_mode;    // no idling on either side
    bit  hold_off;     // long receiver stall
    int  hold_cnt;
    bit  in_taken = 1'b0;   // input transaction accepted at the last rising edge

    // arctangent table, degrees with 24 fraction bits
    longint tilt_atan[24] = '{
        754974720, 445687602, 235489089, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115
    };

    // floor shift for signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring cordic: angle of (xv, yv) in degrees q24, magnitude out
    function automatic longint vector_angle(longint xv, longint yv, output longint mag);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (yv == 0) begin
            mag = xv < 0 ? -xv : xv;
            return xv < 0 ? (longint'(180) << 24) : 0;
        end
        if (xv == 0) begin
            mag = yv < 0 ? -yv : yv;
            return yv > 0 ? (longint'(90) << 24) : -(longint'(90) << 24);
        end
        // pre-rotate the left half plane by a quarter turn
        if (xv < 0) begin
            if (yv > 0) begin
                t = xv; xv = yv; yv = -t; acc = longint'(90) << 24;
            end else begin
                t = xv; xv = -yv; yv = t; acc = -(longint'(90) << 24);
            end
        end
        for (int i = 0; i < N_STG; i++) begin
            dx = floor_shift(yv, i);
            dy = floor_shift(xv, i);
            if (yv >= 0) begin
                xv += dx; yv -= dy; acc += tilt_atan[i];
            end else begin
                xv -= dx; yv += dy; acc -= tilt_atan[i];
            end
        end
        mag = xv;
        return acc;
    endfunction

    // round to output lsb, ties away from zero, then clamp to +-limit
    function automatic longint quantize_angle(longint acc, longint limit_deg);
        longint m;
        int     s;
        s = 24 - ANGLE_FRAC_BITS;
        m = acc < 0 ? -acc : acc;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        if (m > (limit_deg << ANGLE_FRAC_BITS)) begin
            m = limit_deg << ANGLE_FRAC_BITS;
        end
        return acc < 0 ? -m : m;
    endfunction

    function automatic t_angles predict_tilt(t_sample smp);
        longint  ax;
        longint  ay;
        longint  az;
        longint  mag;
        longint  r;
        longint  spare;
        longint  roll_acc;
        longint  pitch_acc;
        t_angles res;
        ax = smp.ax;
        ay = smp.ay;
        az = smp.az;
        roll_acc = vector_angle(az <<< 14, ay <<< 14, mag);
        // gain removed only when both roll inputs are nonzero
        if (ay == 0 && az == 0) begin
            r = 0;
        end else if (ay == 0 || az == 0) begin
            r = mag;
        end else begin
            r = (mag * longint'(652032874)) >>> 30;
        end
        if (ax == 0) begin
            pitch_acc = 0;
        end else begin
            pitch_acc = vector_angle(r, -(ax <<< 14), spare);
        end
        res.roll  = ROLL_W'(quantize_angle(roll_acc, 180));
        res.pitch = PITCH_W'(quantize_angle(pitch_acc, 90));
        return res;
    endfunction

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_sample(logic signed [15:0] x, logic signed [15:0] y,
                                         logic signed [15:0] z);
        t_sample smp;
        smp.ax = x;
        smp.ay = y;
        smp.az = z;
        pending_samples.push_back(smp);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver: new transaction presented at the falling edge
    initial begin
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
    end

    // input acceptance observed at the rising edge, prediction queued here
    always @(posedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            expected_angles.push_back(predict_tilt({sample_ch.accel_x,
                sample_ch.accel_y, sample_ch.accel_z}));
            n_sent++;
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        t_sample smp;
        if (i_rst_n) begin
            if (!sample_ch.valid || in_taken) begin
                if (pending_samples.size() > 0
                        && (calm_mode || $urandom_range(0, 99) >= 19)) begin
                    smp = pending_samples.pop_front();
                    sample_ch.valid   <= 1'b1;
                    sample_ch.accel_x <= smp.ax;
                    sample_ch.accel_y <= smp.ay;
                    sample_ch.accel_z <= smp.az;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with a long hold-off counted here
    initial angle_ch.ready = 1'b0;

    always @(negedge i_clk) begin
        if (hold_off) begin
            hold_cnt++;
            angle_ch.ready <= 1'b0;
        end else if (!i_rst_n) begin
            angle_ch.ready <= 1'b0;
        end else begin
            angle_ch.ready <= calm_mode || ($urandom_range(0, 99) >= 19);
        end
    end

    // monitor: compare each delivered angle pair with the oldest prediction
    always @(posedge i_clk) begin
        t_angles exp_a;
        if (i_rst_n && angle_ch.valid && angle_ch.ready) begin
            if (expected_angles.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected angle transaction: roll %0d pitch %0d",
                             angle_ch.roll_angle, angle_ch.pitch_angle);
                end
            end else begin
                exp_a = expected_angles.pop_front();
                if (exp_a.roll !== angle_ch.roll_angle
                        || exp_a.pitch !== angle_ch.pitch_angle) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("angle mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                                 exp_a.roll, angle_ch.roll_angle,
                                 exp_a.pitch, angle_ch.pitch_angle);
                    end
                end
                n_checked++;
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout with %0d transactions still expected", expected_angles.size());
        $display("accel_tilt_roll_pitch regression: fail");
        $finish;
    end

    // stimulus and sequencing
    initial begin
        int total;
        n_sent     = 0;
        n_checked  = 0;
        n_mismatch = 0;
        calm_mode  = 0;
        hold_off   = 0;
        hold_cnt   = 0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: zeros, axis-only samples, extremes
        queue_sample(0, 0, 0);
        queue_sample(0, 0, 100);            // roll exactly 0
        queue_sample(0, 0, -100);           // y zero, z negative: +180
        queue_sample(0, 0, 16'sh8000);
        queue_sample(0, 500, 0);            // z zero: +90
        queue_sample(0, -500, 0);           // z zero: -90
        queue_sample(1000, 0, 0);           // only x: -90 pitch
        queue_sample(-1000, 0, 0);          // only x: +90 pitch
        queue_sample(16'sh7fff, 0, 0);
        queue_sample(16'sh8000, 0, 0);
        queue_sample(0, 16'sh7fff, 16'sh7fff);
        queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
        queue_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        queue_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
        queue_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        queue_sample(1, -1, -1);
        queue_sample(-1, 1, -1);
        queue_sample(-1, -1, 1);
        queue_sample(300, 200, 0);
        queue_sample(-300, 0, -200);
        queue_sample(16'shffff, 16'shffff, 16'shffff);
        queue_sample(16'sh5555, 16'shaaaa, 16'sh5555);
        queue_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
        n_special = pending_samples.size();

        // random body with frequent corners
        for (int i = 0; i < 1930; i++) begin
            queue_sample(pick_axis(), pick_axis(), pick_axis());
        end
        total = pending_samples.size();

        // receiver holds off while the sender keeps offering
        wait (n_sent >= 200);
        hold_off = 1;
        wait (hold_cnt >= 120);
        hold_off = 0;

        // stretch with no idling
        wait (n_sent >= 800);
        calm_mode = 1;
        wait (n_sent >= 1200);
        calm_mode = 0;

        wait (n_sent >= total && !sample_ch.valid);
        wait (expected_angles.size() == 0);
        repeat (2 * N_STG + 20) @(posedge i_clk);

        $display("covered %0d samples (%0d corner cases) with %0d angle pairs checked,",
                 total, n_special, n_checked);
        $display("random stalls on both sides and a long output back-pressure stretch");
        if (n_mismatch == 0 && expected_angles.size() == 0) begin
            $display("accel_tilt_roll_pitch regression: pass");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("accel_tilt_roll_pitch regression: fail");
        end
        $finish;
    end

endmodule
